>>> src/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types and constants for the block average pixelate filter.
// ----------------------------------------------------------------------------
package bap_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int MAX_BLOCK_DEF  = 64;
  localparam int DEFAULT_BLOCK  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int BSIZE_W    = 7;
  localparam int DIM_W      = 13;
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int SUM_W      = 20;
  localparam int IDX_W      = 11;
  localparam int STEP_W     = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [BSIZE_W-1:0] BSIZE_RST  = 7'd8;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [CH_W-1:0]    CH_MAX     = 8'hFF;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] average_pixel;
    logic [IDX_W-1:0] block_column;
    logic [IDX_W-1:0] block_row;
    logic             frame_done;
  } out_word_t;

  typedef struct packed {
    logic clr;
    logic norm;
    logic scale;
    logic take;
    logic add;
    logic div_step;
    logic out_load;
  } bap_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scale_done;
    logic blk_end;
    logic out_free;
  } bap_sts_t;

endpackage

>>> src/bap_datapath.sv
// ----------------------------------------------------------------------------
// bap_datapath
// Position tracking, per-block-column sum memory, serial dividers and output word.
// ----------------------------------------------------------------------------
module bap_datapath
  import bap_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_BLOCK  = MAX_BLOCK_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_word_t              in_data,
  input  bap_cmd_t              cmd,
  output bap_sts_t              sts,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_word_t             out_data
);

  localparam int SMAX   = (MAX_BLOCK > DEFAULT_BLOCK) ? MAX_BLOCK : DEFAULT_BLOCK;
  localparam int SW     = $clog2(SMAX + 1);
  localparam int OW     = $clog2(SMAX);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int SDEPTH = (MAX_WIDTH + 1) / 2;
  localparam int YDEPTH = (MAX_HEIGHT + 1) / 2;
  localparam int BXW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int BYW    = (YDEPTH > 1) ? $clog2(YDEPTH) : 1;
  localparam int CNTW   = $clog2(SMAX * SMAX + 1);
  localparam int ENT_W  = NUM_CH * SUM_W;

  logic [BSIZE_W-1:0] bsize_r;
  logic [DIM_W-1:0]   fw_r, fh_r;
  logic [SW-1:0]      s;
  logic [WW-1:0]      w;
  logic [HW-1:0]      h;

  logic [CW-1:0]  col_r, col_nxt, xacc_r, xacc_nxt;
  logic [RW-1:0]  row_r, row_nxt, yacc_r, yacc_nxt;
  logic [OW-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic [BXW-1:0] bx_r, bx_nxt, clr_r;
  logic [BYW-1:0] by_r, by_nxt;

  logic [PIX_W-1:0] pix_r;
  logic [ENT_W-1:0] mem [SDEPTH];
  logic [ENT_W-1:0] rd_r, wr_data;
  logic [BXW-1:0]   wr_addr;
  logic             wr_en;

  logic [SUM_W-1:0] quo_r [NUM_CH];
  logic [CNTW-1:0]  rem_r [NUM_CH];
  logic [CNTW-1:0]  cnt_r;
  logic [IDX_W-1:0] res_bx_r, res_by_r;
  logic             res_fd_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic [CW-1:0] c_norm;
  logic [RW-1:0] r_norm;
  logic [RW:0]   r_inc;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          x_last, y_last, first, col_end, row_end;
  logic          x_fit, y_fit;
  logic [31:0]   bx_wide, by_wide;
  logic [PIX_W-1:0] avg;

  // Effective settings.
  always_comb begin
    if (bsize_r < BSIZE_W'(2)) begin
      s = SW'(DEFAULT_BLOCK);
    end else if (32'(bsize_r) > MAX_BLOCK) begin
      s = SW'(MAX_BLOCK);
    end else begin
      s = SW'(bsize_r);
    end
    if (fw_r == '0) begin
      w = WW'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(fw_r);
    end
    if (fh_r == '0) begin
      h = HW'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(fh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= BSIZE_RST;
      fw_r    <= WIDTH_RST;
      fh_r    <= HEIGHT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE:   bsize_r <= cfg_wdata[BSIZE_W-1:0];
        CFG_FRAME_WIDTH:  fw_r    <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT: fh_r    <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A settings change can leave the position outside the frame.
  always_comb begin
    if (32'(col_r) >= 32'(w)) begin
      c_norm = '0;
      r_inc  = {1'b0, row_r} + 1'b1;
    end else begin
      c_norm = col_r;
      r_inc  = {1'b0, row_r};
    end
    if (32'(r_inc) >= 32'(h)) begin
      r_norm = '0;
    end else begin
      r_norm = r_inc[RW-1:0];
    end
  end

  assign x_fit   = 32'(xacc_r) >= 32'(s);
  assign y_fit   = 32'(yacc_r) >= 32'(s);
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign col_end = 32'(col_inc) >= 32'(w);
  assign row_end = 32'(row_inc) >= 32'(h);
  assign x_last  = 32'(ox_r) + 1 == 32'(s);
  assign y_last  = 32'(oy_r) + 1 == 32'(s);
  assign first   = (ox_r == '0) && (oy_r == '0);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    bx_nxt   = bx_r;
    by_nxt   = by_r;
    xacc_nxt = xacc_r;
    yacc_nxt = yacc_r;
    priority if (cmd.norm) begin
      col_nxt  = c_norm;
      row_nxt  = r_norm;
      xacc_nxt = c_norm;
      yacc_nxt = r_norm;
      bx_nxt   = '0;
      by_nxt   = '0;
    end else if (cmd.scale) begin
      // Block indices by repeated subtraction of the block size.
      if (x_fit) begin
        xacc_nxt = xacc_r - CW'(s);
        bx_nxt   = bx_r + 1'b1;
      end
      if (y_fit) begin
        yacc_nxt = yacc_r - RW'(s);
        by_nxt   = by_r + 1'b1;
      end
      if (!x_fit && !y_fit) begin
        ox_nxt = OW'(xacc_r);
        oy_nxt = OW'(yacc_r);
      end
    end else if (cmd.take) begin
      if (in_data.frame_start) begin
        col_nxt = '0;
        row_nxt = '0;
        ox_nxt  = '0;
        oy_nxt  = '0;
        bx_nxt  = '0;
        by_nxt  = '0;
      end
    end else if (cmd.add) begin
      if (col_end) begin
        col_nxt = '0;
        ox_nxt  = '0;
        bx_nxt  = '0;
        if (row_end) begin
          row_nxt = '0;
          oy_nxt  = '0;
          by_nxt  = '0;
        end else begin
          row_nxt = row_inc[RW-1:0];
          if (y_last) begin
            oy_nxt = '0;
            by_nxt = by_r + 1'b1;
          end else begin
            oy_nxt = oy_r + 1'b1;
          end
        end
      end else begin
        col_nxt = col_inc[CW-1:0];
        if (x_last) begin
          ox_nxt = '0;
          bx_nxt = bx_r + 1'b1;
        end else begin
          ox_nxt = ox_r + 1'b1;
        end
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      bx_r   <= '0;
      by_r   <= '0;
      xacc_r <= '0;
      yacc_r <= '0;
      clr_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      bx_r   <= bx_nxt;
      by_r   <= by_nxt;
      xacc_r <= xacc_nxt;
      yacc_r <= yacc_nxt;
      if (cmd.clr) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix_r <= in_data.pixel;
    end
  end

  // New sums for the pixel's block column; the first pixel of a block loads, and a clear writes zeros.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (first) begin
        wr_data[c*SUM_W +: SUM_W] = SUM_W'(pix_r[c*CH_W +: CH_W]);
      end else begin
        wr_data[c*SUM_W +: SUM_W] = rd_r[c*SUM_W +: SUM_W] + SUM_W'(pix_r[c*CH_W +: CH_W]);
      end
    end
    if (cmd.clr) begin
      wr_data = '0;
    end
  end

  assign wr_en   = cmd.clr || cmd.add;
  assign wr_addr = cmd.clr ? clr_r : bx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[bx_r];
  end

  assign bx_wide = 32'(bx_r);
  assign by_wide = 32'(by_r);

  // Restoring division, one quotient bit per channel each step.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      for (int c = 0; c < NUM_CH; c++) begin
        quo_r[c] <= wr_data[c*SUM_W +: SUM_W];
        rem_r[c] <= '0;
      end
      cnt_r    <= CNTW'((32'(ox_r) + 1) * (32'(oy_r) + 1));
      res_bx_r <= bx_wide[IDX_W-1:0];
      res_by_r <= by_wide[IDX_W-1:0];
      res_fd_r <= col_end && row_end;
    end else if (cmd.div_step) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if ({rem_r[c], quo_r[c][SUM_W-1]} >= {1'b0, cnt_r}) begin
          rem_r[c] <= CNTW'({rem_r[c], quo_r[c][SUM_W-1]} - {1'b0, cnt_r});
          quo_r[c] <= {quo_r[c][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[c] <= CNTW'({rem_r[c], quo_r[c][SUM_W-1]});
          quo_r[c] <= {quo_r[c][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (quo_r[c] > SUM_W'(CH_MAX)) begin
        avg[c*CH_W +: CH_W] = CH_MAX;
      end else begin
        avg[c*CH_W +: CH_W] = quo_r[c][CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.average_pixel <= avg;
      out_data_r.block_column  <= res_bx_r;
      out_data_r.block_row     <= res_by_r;
      out_data_r.frame_done    <= res_fd_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign sts.clr_last   = 32'(clr_r) == SDEPTH - 1;
  assign sts.scale_done = !x_fit && !y_fit;
  assign sts.blk_end    = (x_last || col_end) && (y_last || row_end);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

>>> src/bap_ctrl.sv
// ----------------------------------------------------------------------------
// bap_ctrl
// Sequencer for the clearing pass, position recompute and per-pixel steps.
// ----------------------------------------------------------------------------
module bap_ctrl
  import bap_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wen,
  input  logic     in_valid,
  output logic     in_stall,
  output bap_cmd_t cmd,
  input  bap_sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_NORM, S_SCALE, S_READ, S_ADD, S_DIV, S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic              pend_r, pend_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_stall = (state_r != S_IDLE) || pend_r;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r || cfg_wen;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (pend_r) begin
          state_nxt = S_NORM;
        end else if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_NORM: begin
        // Settings changed: bring the position back into the frame.
        cmd.norm  = 1'b1;
        pend_nxt  = cfg_wen;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        if (sts.scale_done) state_nxt = S_IDLE;
      end
      S_READ: state_nxt = S_ADD;
      S_ADD: begin
        cmd.add  = 1'b1;
        step_nxt = '0;
        state_nxt = sts.blk_end ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pend_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

>>> src/block_average_pixelate.sv
// ----------------------------------------------------------------------------
// block_average_pixelate
// Mosaic filter: per-block RGBA channel averages over a raster pixel stream.
// ----------------------------------------------------------------------------
// After acceptance a pixel passes through the read and add steps before the next one is taken.
// A pixel that closes a block then runs the 20-step serial dividers, one per channel and stepped
// together, and waits until the output register is free; its word shows on out_* as input resumes.
// After reset a clearing pass zeroes all (MAX_WIDTH+1)/2 entries of the sum memory.
// After a settings write, the position is brought back into the frame and block indices are
// rebuilt by subtraction, and no pixel is taken until that is done.
module block_average_pixelate
  import bap_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_BLOCK  = MAX_BLOCK_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data
);

  bap_cmd_t cmd;
  bap_sts_t sts;

  bap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wen  (cfg_wen),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bap_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> src/bap_checker.sv
// ----------------------------------------------------------------------------
// bap_checker
// Port-level checks for the block average pixelate filter.
// ----------------------------------------------------------------------------
module bap_checker
  import bap_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

  // Reset starts the clearing pass with nothing on the output.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

  // One word is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

endmodule

bind block_average_pixelate bap_checker u_chk (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_average_pixelate. It sends a directed table
// and then random raster frames under several block and frame settings. The
// table's expected words and a filter model predict each block average, and
// each output word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import bap_pkg::*;

  localparam int SUM_DEPTH   = (MAX_WIDTH_DEF + 1) / 2;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_LEN    = 400;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_word_t              word;
    bit                    typed;
    out_word_t             result;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;

  block_average_pixelate uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Filter state as the bench sees it.
  logic [BSIZE_W-1:0] bsize_reg;
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [SUM_W-1:0]   chan_sum [SUM_DEPTH][NUM_CH];
  int unsigned        pos_col;
  int unsigned        pos_row;

  out_word_t   pending_avgs[$];
  stim_row_t   dir_tab[$];
  int          fail_count;
  int          items_sent;
  int          blocks_seen;
  int          cycle_count;
  bit          hold_req;
  int          hold_count;
  int unsigned stall_mode;
  int unsigned chunk_left;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("block_average_pixelate verification failed");
      $finish;
    end
  end

  // Takes one word through the filter model and reports a finished block.
  task automatic average_block(input in_word_t w, output bit closes, output out_word_t res);
    int unsigned s, fw, fh, bc, br, ox, oy, idx, x0, y0, xe, ye, cnt, avg;
    s  = (bsize_reg < 2) ? 8 : ((bsize_reg > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : bsize_reg);
    fw = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
    fh = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg);
    closes = 1'b0;
    res = '0;
    if (w.frame_start) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= fw) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= fh) pos_row = 0;
    bc = pos_col / s;
    ox = pos_col % s;
    br = pos_row / s;
    oy = pos_row % s;
    idx = (bc >= SUM_DEPTH) ? SUM_DEPTH - 1 : bc;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (ox == 0 && oy == 0) chan_sum[idx][ch] = SUM_W'(w.pixel[ch*CH_W +: CH_W]);
      else chan_sum[idx][ch] = chan_sum[idx][ch] + SUM_W'(w.pixel[ch*CH_W +: CH_W]);
    end
    x0 = bc * s;
    y0 = br * s;
    xe = (x0 + s > fw) ? fw : x0 + s;
    ye = (y0 + s > fh) ? fh : y0 + s;
    if (pos_col + 1 == xe && pos_row + 1 == ye) begin
      cnt = (xe - x0) * (ye - y0);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        avg = chan_sum[idx][ch] / cnt;
        res.average_pixel[ch*CH_W +: CH_W] = (avg > CH_MAX) ? CH_MAX : CH_W'(avg);
      end
      res.block_column = IDX_W'(bc);
      res.block_row    = IDX_W'(br);
      res.frame_done   = (pos_col + 1 == fw && pos_row + 1 == fh);
      closes = 1'b1;
    end
    pos_col++;
    if (pos_col >= fw) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= fh) pos_row = 0;
    end
  endtask

  // Offers one word and returns at the edge that accepts it, valid still high.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    bit        closes;
    out_word_t res;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    average_block(w, closes, res);
    if (typed) pending_avgs.push_back(typed_res);
    else if (closes) pending_avgs.push_back(res);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_BLOCK_SIZE:   bsize_reg  = val[BSIZE_W-1:0];
      CFG_FRAME_WIDTH:  width_reg  = val;
      CFG_FRAME_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '{ROW_CFG, idx, val, '0, 1'b0, '0};
    dir_tab.push_back(r);
  endfunction

  function automatic void add_pix(logic [PIX_W-1:0] px, logic fs, bit typed, out_word_t res);
    stim_row_t r;
    r = '{ROW_PIX, CFG_BLOCK_SIZE, '0, '{px, fs}, typed, res};
    dir_tab.push_back(r);
  endfunction

  // Output side: checks words and stalls on its own pattern.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (pending_avgs.size() == 0) begin
        $error("unexpected output word %h", out_data);
        fail_count++;
      end else begin
        if (out_data.average_pixel !== pending_avgs[0].average_pixel) begin
          $error("average_pixel: expected %h, actual %h",
                 pending_avgs[0].average_pixel, out_data.average_pixel);
          fail_count++;
        end
        if (out_data.block_column !== pending_avgs[0].block_column) begin
          $error("block_column: expected %0d, actual %0d",
                 pending_avgs[0].block_column, out_data.block_column);
          fail_count++;
        end
        if (out_data.block_row !== pending_avgs[0].block_row) begin
          $error("block_row: expected %0d, actual %0d",
                 pending_avgs[0].block_row, out_data.block_row);
          fail_count++;
        end
        if (out_data.frame_done !== pending_avgs[0].frame_done) begin
          $error("frame_done: expected %0d, actual %0d",
                 pending_avgs[0].frame_done, out_data.frame_done);
          fail_count++;
        end
        void'(pending_avgs.pop_front());
        blocks_seen++;
      end
    end
    if (chunk_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      chunk_left = $urandom_range(8, 80);
    end else begin
      chunk_left--;
    end
    // One long hold lets the filter back up and stall its input.
    if (hold_req && hold_count < HOLD_LEN) begin
      hold_count++;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin
    int unsigned burst_left, n_items, pick;
    in_word_t    w;
    fail_count  = 0;
    items_sent  = 0;
    blocks_seen = 0;
    cycle_count = 0;
    hold_count  = 0;
    chunk_left  = 0;
    stall_mode  = 0;
    hold_req    = 1'b0;
    out_stall   = 1'b0;
    rst_n       = 1'b0;
    cfg_wen     = 1'b0;
    cfg_index   = CFG_BLOCK_SIZE;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    bsize_reg   = BSIZE_RST;
    width_reg   = WIDTH_RST;
    height_reg  = HEIGHT_RST;
    pos_col     = 0;
    pos_row     = 0;
    for (int i = 0; i < SUM_DEPTH; i++)
      for (int ch = 0; ch < NUM_CH; ch++) chan_sum[i][ch] = '0;

    // A single 2x2 block, saturated and then empty, the second frame by wrap.
    add_cfg(CFG_BLOCK_SIZE, 13'd2);
    add_cfg(CFG_FRAME_WIDTH, 13'd2);
    add_cfg(CFG_FRAME_HEIGHT, 13'd2);
    add_pix(32'hFFFF_FFFF, 1'b1, 0, '0);
    add_pix(32'hFFFF_FFFF, 1'b0, 0, '0);
    add_pix(32'hFFFF_FFFF, 1'b0, 0, '0);
    add_pix(32'hFFFF_FFFF, 1'b0, 1, '{32'hFFFF_FFFF, 11'd0, 11'd0, 1'b1});
    add_pix(32'h0000_0000, 1'b0, 0, '0);
    add_pix(32'h0000_0000, 1'b0, 0, '0);
    add_pix(32'h0000_0000, 1'b0, 0, '0);
    add_pix(32'h0000_0000, 1'b0, 1, '{32'h0000_0000, 11'd0, 11'd0, 1'b1});
    // Zero dimensions make a one-pixel frame; each pixel is its own average.
    add_cfg(CFG_FRAME_WIDTH, 13'd0);
    add_cfg(CFG_FRAME_HEIGHT, 13'd0);
    add_cfg(CFG_BLOCK_SIZE, 13'd0);
    add_pix(32'h1234_5678, 1'b1, 1, '{32'h1234_5678, 11'd0, 11'd0, 1'b1});
    add_pix(32'h8000_0001, 1'b0, 1, '{32'h8000_0001, 11'd0, 11'd0, 1'b1});
    // A block size of one means eight, clipped here to a 3x1 frame.
    add_cfg(CFG_BLOCK_SIZE, 13'd1);
    add_cfg(CFG_FRAME_WIDTH, 13'd3);
    add_cfg(CFG_FRAME_HEIGHT, 13'd1);
    add_pix(32'h0000_0003, 1'b1, 0, '0);
    add_pix(32'h0000_0006, 1'b0, 0, '0);
    add_pix(32'h0000_0009, 1'b0, 1, '{32'h0000_0006, 11'd0, 11'd0, 1'b1});
    // Oversized settings clamp to the maximum.
    add_cfg(CFG_BLOCK_SIZE, 13'd127);
    add_cfg(CFG_FRAME_WIDTH, 13'd8191);
    add_cfg(CFG_FRAME_HEIGHT, 13'd8191);
    add_pix(32'hA5C3_3C5A, 1'b1, 0, '0);
    add_pix(32'h5A3C_C3A5, 1'b0, 0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      else send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].result);
    end

    for (int ph = 0; ph < 12; ph++) begin
      pick = $urandom_range(0, 9);
      write_reg(CFG_BLOCK_SIZE, (pick == 0) ? $urandom_range(0, 1) :
                                (pick == 1) ? $urandom_range(64, 127) : $urandom_range(2, 8));
      write_reg(CFG_FRAME_WIDTH, (ph == 5) ? 8191 :
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40));
      write_reg(CFG_FRAME_HEIGHT, (ph == 5) ? 4096 :
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16));
      if (ph == 3) hold_req <= 1'b1;
      n_items    = (ph == 5) ? 60 : 160;
      burst_left = $urandom_range(1, 30);
      for (int i = 0; i < n_items; i++) begin
        pick = $urandom_range(0, 7);
        w.pixel = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'h0 : $urandom;
        w.frame_start = (i == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 99) == 0;
        send_word(w, 1'b0, '0);
        if (ph != 3 && --burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = $urandom_range(1, 30);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d pixels over 12 random setting phases plus the directed table.",
             items_sent);
    $display("Checked %0d block averages, including clamped and wrapped settings.",
             blocks_seen);
    if (fail_count == 0) $display("block_average_pixelate verification clean");
    else $display("block_average_pixelate verification failed");
    $finish;
  end

endmodule
